// ===== rtl/m3i_pkg.sv =====
// Shared types and widths for the 3x3 matrix inverse pipeline.
package m3i_pkg;

  // number of matrix elements per word
  localparam int unsigned NELEM = 9;

  // element, cofactor and determinant widths
  localparam int unsigned EW   = 16;
  localparam int unsigned CW   = 33;
  localparam int unsigned DETW = 50;
  localparam int unsigned MAGW = 48;

  // divider widths: rounded numerator, doubled divisor, quotient bits
  localparam int unsigned NW = 57;
  localparam int unsigned DW = 49;
  localparam int unsigned QW = 32;

  typedef logic signed [EW-1:0]   elem_t;
  typedef logic signed [CW-1:0]   cof_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic signed [QW-1:0]   res_t;

  localparam res_t SAT_POS = 32'sh7fff_ffff;
  localparam res_t SAT_NEG = 32'sh8000_0000;

endpackage

// ===== rtl/m3i_cofactor.sv =====
// Four-stage front end: 2x2 products, adjugate entries, determinant.
module m3i_cofactor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  m3i_pkg::elem_t        m [m3i_pkg::NELEM],
  output logic                  out_vld,
  output m3i_pkg::cof_t         adj [m3i_pkg::NELEM],
  output m3i_pkg::det_t         det
);

  logic                  vld [4];
  logic signed [31:0]    pa [m3i_pkg::NELEM];
  logic signed [31:0]    pb [m3i_pkg::NELEM];
  m3i_pkg::elem_t        row1 [3];
  m3i_pkg::elem_t        row2 [3];
  m3i_pkg::cof_t         cof2 [m3i_pkg::NELEM];
  m3i_pkg::cof_t         cof3 [m3i_pkg::NELEM];
  logic signed [48:0]    dp [3];

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 4; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int s = 1; s < 4; s++) vld[s] <= vld[s-1];
    end
  end

  // stage 1: both products of each 2x2 minor
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pa[i*3+j] <= m[J1*3+I1] * m[J2*3+I2];
          pb[i*3+j] <= m[J1*3+I2] * m[J2*3+I1];
        end
      end
    end
  end

  // stage 2: adjugate entries; stage 3: row 0 times first adjugate column
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) row1[k] <= m[k];
      for (int k = 0; k < 3; k++) row2[k] <= row1[k];
      for (int k = 0; k < m3i_pkg::NELEM; k++) begin
        cof2[k] <= m3i_pkg::cof_t'(pa[k]) - m3i_pkg::cof_t'(pb[k]);
        cof3[k] <= cof2[k];
        adj[k]  <= cof3[k];
      end
      for (int k = 0; k < 3; k++) dp[k] <= row2[k] * cof2[k*3];
    end
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det <= m3i_pkg::det_t'(dp[0]) + m3i_pkg::det_t'(dp[1]) + m3i_pkg::det_t'(dp[2]);
    end
  end

  assign out_vld = vld[3];

endmodule

// ===== rtl/m3i_divider.sv =====
// Nine pipelined restoring dividers, one quotient bit per stage, with rounding.
module m3i_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  m3i_pkg::cof_t         adj [m3i_pkg::NELEM],
  input  m3i_pkg::det_t         det,
  output logic                  out_vld,
  output m3i_pkg::res_t         inv [m3i_pkg::NELEM],
  output logic                  singular
);

  localparam int unsigned QW = m3i_pkg::QW;
  localparam int unsigned NW = m3i_pkg::NW;
  localparam int unsigned DW = m3i_pkg::DW;

  // stage A: magnitudes and signs
  logic                      va;
  logic [31:0]               mca [m3i_pkg::NELEM];
  logic                      nega [m3i_pkg::NELEM];
  logic [m3i_pkg::MAGW-1:0]  mda;
  logic                      dza;
  m3i_pkg::det_t             det_abs;

  assign det_abs = det[m3i_pkg::DETW-1] ? -det : det;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::NELEM; k++) begin
        mca[k]  <= adj[k][m3i_pkg::CW-1] ? 32'(-adj[k]) : 32'(adj[k]);
        nega[k] <= adj[k][m3i_pkg::CW-1] ^ det[m3i_pkg::DETW-1];
      end
      mda <= det_abs[m3i_pkg::MAGW-1:0];
      dza <= (det == '0);
    end
  end

  // divider stage registers; index 0 is the rounded numerator stage
  logic           vld  [QW+2];
  logic [NW-1:0]  rem  [QW+1][m3i_pkg::NELEM];
  logic [QW-1:0]  quo  [QW+1][m3i_pkg::NELEM];
  logic           neg  [QW+1][m3i_pkg::NELEM];
  logic           ovf  [QW+1][m3i_pkg::NELEM];
  logic [DW-1:0]  dvs  [QW+1];
  logic           dz   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW + 2; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= va;
      for (int s = 1; s < QW + 2; s++) vld[s] <= vld[s-1];
    end
  end

  // stage B: round-half-up numerator 2*c*2^24 + d over divisor 2*d
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::NELEM; k++) begin
        rem[0][k] <= {mca[k], 25'b0} + NW'(mda);
        quo[0][k] <= '0;
        neg[0][k] <= nega[k];
        ovf[0][k] <= {24'b0, mca[k], 25'b0} + 81'(mda) >= {mda, 1'b0, 32'b0};
      end
      dvs[0] <= {mda, 1'b0};
      dz[0]  <= dza;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    for (genvar e = 0; e < m3i_pkg::NELEM; e++) begin : g_ent
      logic [NW-1:0] shifted;
      logic          take;
      assign shifted = rem[s][e] >> K;
      assign take    = shifted >= NW'(dvs[s]);
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1][e] <= take ? rem[s][e] - (NW'(dvs[s]) << K) : rem[s][e];
          quo[s+1][e] <= {quo[s][e][QW-2:0], take};
          neg[s+1][e] <= neg[s][e];
          ovf[s+1][e] <= ovf[s][e];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dvs[s+1] <= dvs[s];
        dz[s+1]  <= dz[s];
      end
    end
  end

  // output stage: sign, saturation, singular case
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < m3i_pkg::NELEM; k++) begin
        if (dz[QW]) begin
          inv[k] <= '0;
        end else if (neg[QW][k]) begin
          inv[k] <= (ovf[QW][k] || quo[QW][k][QW-1]) ? m3i_pkg::SAT_NEG
                                                     : -m3i_pkg::res_t'(quo[QW][k]);
        end else begin
          inv[k] <= (ovf[QW][k] || quo[QW][k][QW-1]) ? m3i_pkg::SAT_POS
                                                     : m3i_pkg::res_t'(quo[QW][k]);
        end
      end
      singular <= dz[QW];
    end
  end

  assign out_vld = vld[QW+1];

  // quotient fits in 32 bits unless flagged as overflow
  a_fit: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !ovf[0][0] |-> (rem[0][0] >> QW) < NW'(dvs[0]))
    else $error("numerator exceeds 32-bit quotient range");

  // restoring division leaves a remainder below the divisor
  a_rem: assert property (@(posedge clk) disable iff (rst)
    vld[QW] && !dz[QW] && !ovf[QW][4] |-> rem[QW][4] < NW'(dvs[QW]))
    else $error("final remainder not below divisor");

  // singular words carry all-zero entries
  a_sing: assert property (@(posedge clk) disable iff (rst)
    out_vld && singular |-> inv[0] == '0 && inv[4] == '0 && inv[8] == '0)
    else $error("singular word with nonzero entry");

endmodule

// ===== rtl/matrix3x3_inverse_top.sv =====
// 3x3 matrix inverse by adjugate: Q8.8 matrix in, Q16.16 saturated inverse out.
//
// Input channel: in_valid/in_ready with nine Q8.8 elements m_rRcC, row-major.
// Output channel: out_valid/out_ready with nine Q16.16 entries inv_rRcC and
// a singular flag; a singular word (determinant exactly zero) has all
// entries zero. Entries are rounded to nearest, ties away from zero.
//
// Fully pipelined: one matrix per cycle sustained while out_ready keeps up.
// There are 39 register stages between an accepted word and out_valid.
// Four stages form products, adjugate and determinant; two prepare
// magnitudes and the rounded numerator; 32 stages each resolve one quotient
// bit for all nine entries; one stage saturates.
//
// When out_ready is low with a word waiting, the whole pipeline holds and
// in_ready drops; bubbles in flight are not squeezed out while it holds.
// Nothing is dropped or repeated across a stall.
// Reset clears all valid bits and holds in_ready low while rst is high.
module matrix3x3_inverse_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  m_r0c0,
  input  logic [15:0]  m_r0c1,
  input  logic [15:0]  m_r0c2,
  input  logic [15:0]  m_r1c0,
  input  logic [15:0]  m_r1c1,
  input  logic [15:0]  m_r1c2,
  input  logic [15:0]  m_r2c0,
  input  logic [15:0]  m_r2c1,
  input  logic [15:0]  m_r2c2,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  inv_r0c0,
  output logic [31:0]  inv_r0c1,
  output logic [31:0]  inv_r0c2,
  output logic [31:0]  inv_r1c0,
  output logic [31:0]  inv_r1c1,
  output logic [31:0]  inv_r1c2,
  output logic [31:0]  inv_r2c0,
  output logic [31:0]  inv_r2c1,
  output logic [31:0]  inv_r2c2,
  output logic         singular
);

  logic                en;
  logic                cf_vld;
  m3i_pkg::elem_t      m [m3i_pkg::NELEM];
  m3i_pkg::cof_t       adj [m3i_pkg::NELEM];
  m3i_pkg::det_t       det;
  m3i_pkg::res_t       inv [m3i_pkg::NELEM];

  // pipeline advances unless a finished word is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  assign m[0] = m_r0c0;
  assign m[1] = m_r0c1;
  assign m[2] = m_r0c2;
  assign m[3] = m_r1c0;
  assign m[4] = m_r1c1;
  assign m[5] = m_r1c2;
  assign m[6] = m_r2c0;
  assign m[7] = m_r2c1;
  assign m[8] = m_r2c2;

  m3i_cofactor u_cof (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid),
    .m       (m),
    .out_vld (cf_vld),
    .adj     (adj),
    .det     (det)
  );

  m3i_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (cf_vld),
    .adj      (adj),
    .det      (det),
    .out_vld  (out_valid),
    .inv      (inv),
    .singular (singular)
  );

  assign inv_r0c0 = inv[0];
  assign inv_r0c1 = inv[1];
  assign inv_r0c2 = inv[2];
  assign inv_r1c0 = inv[3];
  assign inv_r1c1 = inv[4];
  assign inv_r1c2 = inv[5];
  assign inv_r2c0 = inv[6];
  assign inv_r2c1 = inv[7];
  assign inv_r2c2 = inv[8];

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the 3x3 matrix inverse pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 39;
  localparam int N_RANDOM = 1700;
  localparam int WATCHDOG = 20000;

  // inverse result word
  typedef struct packed {
    logic [8:0][31:0] ent;
    logic             sing;
  } inv_word_t;

  // idle profiles, in percent
  typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [8:0][15:0] mat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [8:0][31:0] inv;
  logic singular;

  inv_word_t expected_q[$];
  int mismatches = 0;
  int n_checked = 0;
  int n_singular = 0;
  int n_sat = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  matrix3x3_inverse_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .m_r0c0(mat[0]), .m_r0c1(mat[1]), .m_r0c2(mat[2]),
    .m_r1c0(mat[3]), .m_r1c1(mat[4]), .m_r1c2(mat[5]),
    .m_r2c0(mat[6]), .m_r2c1(mat[7]), .m_r2c2(mat[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
    .inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
    .inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
    .singular(singular)
  );

  // round(cof * 2^24 / det), ties away from zero, saturated to 32 bits
  function automatic logic [31:0] scaled_quotient(longint cof, longint det);
    bit neg;
    logic [63:0] mc, md, q;
    neg = (cof < 0) != (det < 0);
    mc = (cof < 0) ? -cof : cof;
    md = (det < 0) ? -det : det;
    q = (2 * (mc << 24) + md) / (2 * md);
    if (cof == 0) return 32'h0;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
  endfunction

  // adjugate divided by determinant
  function automatic inv_word_t invert_matrix(logic [8:0][15:0] m);
    longint a[3][3];
    longint det, cof;
    inv_word_t w;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = longint'($signed(m[i*3+j]));
    det = a[0][0]*a[1][1]*a[2][2] + a[0][2]*a[1][0]*a[2][1]
        + a[0][1]*a[1][2]*a[2][0] - a[0][2]*a[1][1]*a[2][0]
        - a[0][0]*a[1][2]*a[2][1] - a[0][1]*a[1][0]*a[2][2];
    w = '0;
    if (det == 0) begin
      w.sing = 1'b1;
      return w;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cof = a[(j+1)%3][(i+1)%3] * a[(j+2)%3][(i+2)%3]
            - a[(j+1)%3][(i+2)%3] * a[(j+2)%3][(i+1)%3];
        w.ent[i*3+j] = scaled_quotient(cof, det);
      end
    return w;
  endfunction

  // drive one word and wait for acceptance; valid drops only on idle cycles
  task automatic send_word(logic [8:0][15:0] m);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mat <= m;
    expected_q.push_back(invert_matrix(m));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(1024)) - 512);
      3: return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [8:0][15:0] rand_matrix();
    logic [8:0][15:0] m;
    int k;
    for (int i = 0; i < 9; i++) m[i] = rand_elem();
    k = $urandom_range(9);
    // make some singular: copy a row or zero one
    if (k == 0) for (int j = 0; j < 3; j++) m[3+j] = m[j];
    if (k == 1) for (int j = 0; j < 3; j++) m[6+j] = 16'h0;
    // random full-range diagonal with small off-diagonals
    if (k == 2) for (int i = 0; i < 9; i++)
      m[i] = (i % 4 == 0) ? 16'($urandom) : 16'($signed($urandom_range(64)) - 32);
    return m;
  endfunction

  // sink side: random stall plus the long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    inv_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h %b", inv, singular);
      end else begin
        exp_w = expected_q.pop_front();
        n_checked++;
        if (exp_w.sing) n_singular++;
        for (int i = 0; i < 9; i++)
          if (exp_w.ent[i] == 32'h7fff_ffff || exp_w.ent[i] == 32'h8000_0000) n_sat++;
        if (exp_w.ent !== inv || exp_w.sing !== singular) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected %h sing %b, got %h sing %b",
                     n_checked, exp_w.ent, exp_w.sing, inv, singular);
        end
      end
    end
  end

  // watchdog on cycles with no acceptance
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d words outstanding", expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long receiver hold-off so the pipeline fills and backs up
  initial begin
    wait (stim_done == 1'b0 && n_checked > 100);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // directed words, rows m00..m22
  logic [8:0][15:0] directed_tbl[] = '{
    '{16'h0100,16'h0,16'h0, 16'h0,16'h0100,16'h0, 16'h0,16'h0,16'h0100},
    '{16'h0,16'h0,16'h0, 16'h0,16'h0,16'h0, 16'h0,16'h0,16'h0},
    '{16'h0001,16'h0,16'h0, 16'h0,16'h0001,16'h0, 16'h0,16'h0,16'h0001},
    '{16'h7fff,16'h0,16'h0, 16'h0,16'h7fff,16'h0, 16'h0,16'h0,16'h7fff},
    '{16'h8000,16'h0,16'h0, 16'h0,16'h8000,16'h0, 16'h0,16'h0,16'h8000},
    '{16'h8000,16'h8000,16'h8000, 16'h8000,16'h8000,16'h8000,
      16'h8000,16'h8000,16'h8000},
    '{16'h7fff,16'h8000,16'h7fff, 16'h8000,16'h7fff,16'h8000,
      16'h7fff,16'h8000,16'h8000},
    '{16'hffff,16'hffff,16'hffff, 16'hffff,16'h0001,16'hffff,
      16'hffff,16'hffff,16'h0001},
    '{16'h0200,16'h0,16'h0, 16'h0,16'h0300,16'h0, 16'h0,16'h0,16'h0300},
    '{16'h0100,16'h0200,16'h0300, 16'h0400,16'h0500,16'h0600,
      16'h0700,16'h0800,16'h0900},
    '{16'h0,16'h0100,16'h0, 16'h0,16'h0,16'h0100, 16'h0100,16'h0,16'h0},
    '{16'h0003,16'h0,16'h0, 16'h0,16'h0001,16'h0, 16'h0,16'h0,16'h0001},
    '{16'hff00,16'h0,16'h0, 16'h0,16'hff00,16'h0, 16'h0,16'h0,16'hff00}
  };
  // results readable at a glance: identity, zero matrix, tiny diagonal
  inv_word_t known_tbl[3];

  initial begin
    inv_word_t w;
    known_tbl[0] = '0;
    known_tbl[0].ent[0] = 32'h0001_0000;
    known_tbl[0].ent[4] = 32'h0001_0000;
    known_tbl[0].ent[8] = 32'h0001_0000;
    known_tbl[1] = '0;
    known_tbl[1].sing = 1'b1;
    // 1/256 on the diagonal inverts to 256.0
    known_tbl[2] = '0;
    known_tbl[2].ent[0] = 32'h0100_0000;
    known_tbl[2].ent[4] = 32'h0100_0000;
    known_tbl[2].ent[8] = 32'h0100_0000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_tbl[i]) begin
      if (i < 3) begin
        w = invert_matrix(directed_tbl[i]);
        if (w !== known_tbl[i]) begin
          mismatches++;
          $display("predictor disagrees on directed word %0d", i);
        end
      end
      send_word(directed_tbl[i]);
    end

    // random words across idle profiles
    for (int p = 0; p < 5; p++) begin
      case (phase_e'(p % 4))
        PH_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        PH_SRC:  begin src_idle_pct = 60; snk_stall_pct = 0;  end
        PH_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 60; end
        default: begin src_idle_pct = 21; snk_stall_pct = 21; end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) send_word(rand_matrix());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    wait (expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d inverses, %0d singular, %0d saturated entries",
             n_checked, n_singular, n_sat);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/m3i_pkg.sv
rtl/m3i_cofactor.sv
rtl/m3i_divider.sv
rtl/matrix3x3_inverse_top.sv
tb/sv/testbench.sv
